// ===== src/wildcard_byte_pattern_search_macros.svh =====
// Assertion macros shared by the wildcard byte pattern search RTL.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define WBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define WBPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define WBPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define WBPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/wbps_pkg.sv =====
// Shared types and constants of the wildcard byte pattern search.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int BYTE_W    = 8;
    localparam int SLOT_W    = 5;
    localparam int CFG_W     = 6;
    localparam int OFFSET_W  = 32;
    localparam int S_TDATA_W = 16;

    // Pattern byte that matches any region byte
    localparam logic [BYTE_W-1:0] WILDCARD = 8'h2A;

    // Input beat kinds carried on s_tuser
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_REGION  = 1'b1;

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic              shift;    // region byte accepted, advance window
        logic              clear;    // last byte of region, drop valid marks
        logic              realign;  // shift pattern copy one cell up
        logic              pat_wr;   // pattern byte accepted
        logic [SLOT_W-1:0] pat_slot;
        logic [BYTE_W-1:0] pat_data;
        logic [CFG_W-1:0]  len;      // active pattern length, 1 or more
    } cell_ctrl_t;

endpackage

// ===== src/wbps_cell.sv =====
// One window cell: holds a region byte, its valid mark and the aligned pattern byte.
`timescale 1ns / 1ps

module wbps_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  wbps_pkg::cell_ctrl_t       ctrl,
    input  logic [wbps_pkg::BYTE_W-1:0] byte_in,
    input  logic                       vld_in,
    input  logic [wbps_pkg::BYTE_W-1:0] pat_in,
    output logic [wbps_pkg::BYTE_W-1:0] byte_out,
    output logic                       vld_out,
    output logic [wbps_pkg::BYTE_W-1:0] pat_out,
    output logic                       ok
);

    logic [wbps_pkg::BYTE_W-1:0] byte_reg;
    logic                        vld_reg;
    logic                        vld_next;
    logic [wbps_pkg::BYTE_W-1:0] pat_reg;
    logic                        active;
    logic                        pat_hit;

    // Cell k compares window byte k with pattern byte len-1-k
    assign active  = 32'(IDX) < 32'(ctrl.len);
    assign pat_hit = ctrl.pat_wr &&
                     ((32'(IDX) + 32'(ctrl.pat_slot) + 32'd1) == 32'(ctrl.len));

    // Judge the byte that enters this cell on the current beat
    assign ok = !active ||
                (vld_in && (pat_reg == wbps_pkg::WILDCARD || pat_reg == byte_in));

    // Advance the window byte
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    // Track which window bytes belong to the current region
    always_comb begin
        vld_next = vld_reg;
        if (ctrl.shift) begin
            vld_next = ctrl.clear ? 1'b0 : vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Load the aligned pattern byte by realignment or by direct write
    always_ff @(posedge aclk) begin
        if (ctrl.realign) begin
            pat_reg <= pat_in;
        end else if (pat_hit) begin
            pat_reg <= ctrl.pat_data;
        end
    end

    assign byte_out = byte_reg;
    assign vld_out  = vld_reg;
    assign pat_out  = pat_reg;

endmodule

// ===== src/wildcard_byte_pattern_search.sv =====
// Top level of the wildcard byte pattern search: control, pattern store and cell chain.
// A result beat is registered and appears in the cycle after the region byte that causes it.
// Throughput: one input beat per cycle; s_tready drops while a result beat waits on m_tready.
// After a write of pattern_length, s_tready stays low while the pattern copy in the cells
// is realigned to the new length, clamped to 1..MAX_PATTERN.
// Reset (aresetn low, synchronous) clears the window marks, counters and the output beat.
`timescale 1ns / 1ps

`include "wildcard_byte_pattern_search_macros.svh"

module wildcard_byte_pattern_search #(
    parameter int unsigned MAX_PATTERN = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration: pattern_length
    input  logic                                cfg_we,
    input  logic [wbps_pkg::CFG_W-1:0]          cfg_wdata,
    // Input beats
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: [7:0] data_byte, [12:8] pattern_slot, [15:13] zero
    input  logic [wbps_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,   // [0] command
    input  logic                                s_tlast,   // region_last
    // Result beats
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wbps_pkg::OFFSET_W-1:0]       m_tdata,   // [31:0] match_offset
    output logic                                m_tuser    // [0] found
);

    localparam int unsigned PDEPTH = (MAX_PATTERN < 32) ? MAX_PATTERN : 32;
    localparam int unsigned PIDX_W = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    logic [wbps_pkg::BYTE_W-1:0]   data_byte;
    logic [wbps_pkg::SLOT_W-1:0]   pattern_slot;
    logic                          in_fire;
    logic                          region_beat;
    logic                          pattern_beat;

    logic [wbps_pkg::CFG_W-1:0]    len_reg;
    logic [wbps_pkg::CFG_W-1:0]    len_next;
    logic                          realign_reg;
    logic [wbps_pkg::CFG_W-1:0]    realign_cnt_reg;
    logic [wbps_pkg::BYTE_W-1:0]   realign_feed;
    logic [wbps_pkg::BYTE_W-1:0]   pat_reg [PDEPTH];

    logic [wbps_pkg::OFFSET_W-1:0] count_reg;
    logic [wbps_pkg::OFFSET_W-1:0] count_inc;
    logic                          reported_reg;

    logic                          all_ok;
    logic                          hit;
    logic                          emit;

    logic                          out_valid_reg;
    logic                          out_found_reg;
    logic [wbps_pkg::OFFSET_W-1:0] out_offset_reg;

    wbps_pkg::cell_ctrl_t          ctrl;

    logic [wbps_pkg::BYTE_W-1:0]   cell_byte [MAX_PATTERN];
    logic                          cell_vld  [MAX_PATTERN];
    logic [wbps_pkg::BYTE_W-1:0]   cell_pat  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0]        cell_ok;

    // Unpack the input beat
    assign data_byte    = s_tdata[7:0];
    assign pattern_slot = s_tdata[12:8];
    assign in_fire      = s_tvalid && s_tready;
    assign region_beat  = in_fire && (s_tuser == wbps_pkg::CMD_REGION);
    assign pattern_beat = in_fire && (s_tuser == wbps_pkg::CMD_PATTERN);

    // Accept while the output register frees up and no realignment runs
    assign s_tready = (!out_valid_reg || m_tready) && !realign_reg;

    // Clamp the written length to 1..MAX_PATTERN
    always_comb begin
        if (cfg_wdata == '0) begin
            len_next = wbps_pkg::CFG_W'(1);
        end else if (32'(cfg_wdata) > 32'(MAX_PATTERN)) begin
            len_next = wbps_pkg::CFG_W'(MAX_PATTERN);
        end else begin
            len_next = cfg_wdata;
        end
    end

    // Hold the length and sequence the realignment of the cell pattern copy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg         <= wbps_pkg::CFG_W'(1);
            realign_reg     <= 1'b0;
            realign_cnt_reg <= '0;
        end else if (cfg_we) begin
            len_reg         <= len_next;
            realign_reg     <= 1'b1;
            realign_cnt_reg <= '0;
        end else if (realign_reg) begin
            if ((32'(realign_cnt_reg) + 32'd1) == 32'(len_reg)) begin
                realign_reg <= 1'b0;
            end
            realign_cnt_reg <= realign_cnt_reg + wbps_pkg::CFG_W'(1);
        end
    end

    // Feed pattern bytes in slot order into the bottom of the chain
    always_comb begin
        realign_feed = '0;
        if (32'(realign_cnt_reg) < 32'(PDEPTH)) begin
            realign_feed = pat_reg[realign_cnt_reg[PIDX_W-1:0]];
        end
    end

    // Store pattern bytes by slot
    always_ff @(posedge aclk) begin
        if (pattern_beat && (32'(pattern_slot) < 32'(PDEPTH))) begin
            pat_reg[pattern_slot[PIDX_W-1:0]] <= data_byte;
        end
    end

    // Broadcast control to the cells
    always_comb begin
        ctrl.shift    = region_beat;
        ctrl.clear    = region_beat && s_tlast;
        ctrl.realign  = realign_reg;
        ctrl.pat_wr   = pattern_beat;
        ctrl.pat_slot = pattern_slot;
        ctrl.pat_data = data_byte;
        ctrl.len      = len_reg;
    end

    // Chain of cells, newest byte enters cell 0
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            wbps_cell #(.IDX(k)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .byte_in  (data_byte),
                .vld_in   (1'b1),
                .pat_in   (realign_feed),
                .byte_out (cell_byte[k]),
                .vld_out  (cell_vld[k]),
                .pat_out  (cell_pat[k]),
                .ok       (cell_ok[k])
            );
        end else begin : g_body
            wbps_cell #(.IDX(k)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (ctrl),
                .byte_in  (cell_byte[k-1]),
                .vld_in   (cell_vld[k-1]),
                .pat_in   (cell_pat[k-1]),
                .byte_out (cell_byte[k]),
                .vld_out  (cell_vld[k]),
                .pat_out  (cell_pat[k]),
                .ok       (cell_ok[k])
            );
        end
    end

    // Combine cell verdicts and decide on a result beat
    assign all_ok    = &cell_ok;
    assign hit       = region_beat && !reported_reg && all_ok;
    assign emit      = hit || (region_beat && s_tlast && !reported_reg);
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 32'd1;

    // Advance region counters, clear them after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            reported_reg <= 1'b0;
        end else if (region_beat) begin
            if (s_tlast) begin
                count_reg    <= '0;
                reported_reg <= 1'b0;
            end else begin
                count_reg    <= count_inc;
                reported_reg <= reported_reg || hit;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_found_reg  <= hit;
            out_offset_reg <= hit ? (count_inc - 32'(len_reg)) : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = out_offset_reg;

    // Checks
    `WBPS_ASSERT_NXT(a_hit_gives_found, aclk, aresetn, hit, m_tvalid && m_tuser,
                     "match did not produce a found beat")
    `WBPS_ASSERT_NXT(a_one_result_per_region, aclk, aresetn,
                     region_beat && reported_reg && !s_tlast, !m_tvalid,
                     "second result in one region")
    `WBPS_ASSERT_NXT(a_count_saturates, aclk, aresetn,
                     region_beat && !s_tlast && (count_reg == '1), count_reg == '1,
                     "region count wrapped")
    `WBPS_ASSERT_NXT(a_cfg_stalls_input, aclk, aresetn, cfg_we, !s_tready,
                     "input accepted during realignment")
    `WBPS_ASSERT_IMP(a_notfound_zero_offset, aclk, aresetn, m_tvalid && !m_tuser,
                     m_tdata == '0, "not-found beat with nonzero offset")

endmodule

// ===== verif/wbps_checker.sv =====
// Checker for the wildcard byte pattern search: watches both channels, predicts results and compares.
`timescale 1ns / 1ps

module wbps_checker
    import wbps_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OFFSET_W-1:0]  m_tdata,
    input  logic                 m_tuser,
    output int                   mismatch_count,
    output int                   pending
);

    typedef struct packed {
        logic                found;
        logic [OFFSET_W-1:0] offset;
    } search_result_t;

    // Predicted block state
    logic [BYTE_W-1:0]   pattern_mem [DEPTH];
    logic [BYTE_W-1:0]   window_mem  [DEPTH];
    logic [OFFSET_W-1:0] region_bytes;
    logic                match_seen;
    logic [CFG_W-1:0]    length_reg;

    search_result_t search_results_q[$];

    task automatic flag(input string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] search result mismatch: %s", $time, what);
        end
    endtask

    always @(posedge aclk) begin : watch
        search_result_t want;
        int             eff_len;
        int             i;
        logic           hit;
        logic [BYTE_W-1:0] in_byte;

        if (!aresetn) begin
            // Clear the prediction along with the block
            for (i = 0; i < DEPTH; i++) begin
                pattern_mem[i] = '0;
                window_mem[i]  = '0;
            end
            region_bytes = '0;
            match_seen   = 1'b0;
            length_reg   = CFG_W'(1);
            search_results_q.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_we) begin
                length_reg = cfg_wdata;
            end

            // Predict the outcome of an accepted input beat
            if (s_tvalid && s_tready) begin
                in_byte = s_tdata[BYTE_W-1:0];
                if (s_tuser == CMD_PATTERN) begin
                    // Slot field is 5 bits wide, so it lands inside the store when DEPTH is 32 or more
                    pattern_mem[s_tdata[BYTE_W +: SLOT_W]] = in_byte;
                end else begin
                    for (i = DEPTH - 1; i > 0; i--) begin
                        window_mem[i] = window_mem[i-1];
                    end
                    window_mem[0] = in_byte;
                    if (region_bytes != '1) begin
                        region_bytes++;
                    end

                    // Zero acts as one, anything past the store depth as full depth
                    if (length_reg == 0) begin
                        eff_len = 1;
                    end else if (length_reg > DEPTH) begin
                        eff_len = DEPTH;
                    end else begin
                        eff_len = int'(length_reg);
                    end

                    hit = !match_seen && (region_bytes >= eff_len);
                    for (i = 0; i < eff_len; i++) begin
                        if (pattern_mem[i] != WILDCARD &&
                            pattern_mem[i] != window_mem[eff_len-1-i]) begin
                            hit = 1'b0;
                        end
                    end
                    if (hit) begin
                        match_seen  = 1'b1;
                        want.found  = 1'b1;
                        want.offset = region_bytes - OFFSET_W'(eff_len);
                        search_results_q.push_back(want);
                    end

                    // Report a miss on the closing byte, then start a fresh region
                    if (s_tlast) begin
                        if (!match_seen) begin
                            want.found  = 1'b0;
                            want.offset = '0;
                            search_results_q.push_back(want);
                        end
                        for (i = 0; i < DEPTH; i++) begin
                            window_mem[i] = '0;
                        end
                        region_bytes = '0;
                        match_seen   = 1'b0;
                    end
                end
            end

            // Compare an accepted result beat with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (search_results_q.size() == 0) begin
                    flag($sformatf("unexpected beat found=%0b offset=%0d", m_tuser, m_tdata));
                end else begin
                    want = search_results_q.pop_front();
                    if (m_tuser !== want.found) begin
                        flag($sformatf("found expected %0b got %0b", want.found, m_tuser));
                    end
                    if (m_tdata !== want.offset) begin
                        flag($sformatf("offset expected %0d got %0d", want.offset, m_tdata));
                    end
                end
            end
        end
        pending <= search_results_q.size();
    end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the wildcard byte pattern search: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import wbps_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int DEPTH         = 32;
    localparam int ITEM_TARGET   = 1600;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OFFSET_W-1:0]  m_tdata;
    logic                 m_tuser;

    int mismatch_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // Pattern as last loaded, used to plant matches in regions
    logic [BYTE_W-1:0] pattern_copy [DEPTH];

    wildcard_byte_pattern_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    wbps_checker #(.DEPTH(DEPTH)) u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("wildcard_byte_pattern_search verification failed");
            $finish;
        end
    end

    // Present one beat, idling first at the current rate, and hold it until taken
    task automatic send_beat(input logic cmd, input logic [BYTE_W-1:0] data,
                             input logic [SLOT_W-1:0] slot, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {3'b000, slot, data};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic write_slot(input logic [SLOT_W-1:0] slot, input logic [BYTE_W-1:0] data,
                              input logic last);
        pattern_copy[slot] = data;
        send_beat(CMD_PATTERN, data, slot, last);
    endtask

    task automatic scan_byte(input logic [BYTE_W-1:0] data, input logic last);
        send_beat(CMD_REGION, data, SLOT_W'($urandom), last);
    endtask

    // Write the length register once the block has gone quiet
    task automatic set_length(input logic [CFG_W-1:0] code);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [BYTE_W-1:0] pattern_byte();
        case ($urandom_range(7))
            0, 1:    return WILDCARD;
            2:       return 8'h00;
            3:       return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // One region: noise, mostly with a planted copy of the pattern, sometimes broken
    task automatic send_region(input int eff);
        int                total;
        int                start;
        int                flaw;
        int                i;
        logic              planted;
        logic [BYTE_W-1:0] b;

        if ($urandom_range(9) == 0) begin
            total = $urandom_range(eff, 1);
        end else begin
            total = $urandom_range(3 * eff + 6, eff);
        end
        planted = ($urandom_range(99) < 65) && (total >= eff);
        start   = planted ? $urandom_range(total - eff) : 0;
        flaw    = ($urandom_range(3) == 0) ? $urandom_range(eff - 1) : -1;

        for (i = 0; i < total; i++) begin
            // Occasionally rewrite a slot in the middle of the region
            if ($urandom_range(49) == 0) begin
                write_slot(SLOT_W'($urandom), pattern_byte(), 1'($urandom));
            end
            if (planted && i >= start && i < start + eff) begin
                b = pattern_copy[i-start];
                if (b == WILDCARD) begin
                    b = BYTE_W'($urandom);
                end
                if (i - start == flaw) begin
                    b = ~b;
                end
            end else if ($urandom_range(1) == 0) begin
                b = pattern_copy[$urandom_range(eff - 1)];
            end else begin
                b = BYTE_W'($urandom);
            end
            scan_byte(b, i == total - 1);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] code);
        int eff;
        int k;
        int rounds;

        set_length(code);
        if (code == 0) begin
            eff = 1;
        end else if (code > DEPTH) begin
            eff = DEPTH;
        end else begin
            eff = int'(code);
        end
        for (k = 0; k < eff; k++) begin
            write_slot(SLOT_W'(k), pattern_byte(), 1'($urandom));
        end
        rounds = 120 / (2 * eff + 6);
        if (rounds < 2) begin
            rounds = 2;
        end
        repeat (rounds) send_region(eff);
    endtask

    initial begin
        int               phase;
        int               r;
        logic [CFG_W-1:0] code;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: single-byte pattern at reset length, last flag on a pattern write
        write_slot(5'd0, 8'h00, 1'b1);
        scan_byte(8'h00, 1'b1);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'hFF, 1'b1);
        // Wildcard pattern, bytes after the match carry no result
        write_slot(5'd0, WILDCARD, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(WILDCARD, 1'b1);
        write_slot(5'd31, 8'hFF, 1'b0);

        // Three-byte pattern: short region, match on the last byte, rewrite mid-region
        set_length(CFG_W'(3));
        write_slot(5'd0, 8'hFF, 1'b0);
        write_slot(5'd1, WILDCARD, 1'b0);
        write_slot(5'd2, 8'h00, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h11, 1'b1);
        scan_byte(8'h55, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h13, 1'b0);
        scan_byte(8'h00, 1'b1);
        scan_byte(8'hFF, 1'b0);
        write_slot(5'd2, 8'h7E, 1'b0);
        scan_byte(8'h01, 1'b0);
        scan_byte(8'h7E, 1'b0);
        scan_byte(8'h00, 1'b1);

        // Random phases, cycling through the idle modes
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            case (phase)
                0: code = CFG_W'(32);
                1: code = CFG_W'(0);
                2: code = CFG_W'(63);
                3: code = CFG_W'(33);
                4: code = CFG_W'(1);
                default: begin
                    r = $urandom_range(99);
                    if (r < 55) begin
                        code = CFG_W'($urandom_range(6, 1));
                    end else if (r < 80) begin
                        code = CFG_W'($urandom_range(16, 7));
                    end else if (r < 95) begin
                        code = CFG_W'($urandom_range(32, 17));
                    end else if (r < 97) begin
                        code = CFG_W'(0);
                    end else begin
                        code = CFG_W'($urandom_range(63, 33));
                    end
                end
            endcase
            run_phase(code);
            phase++;
        end

        // Drain outstanding results
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("wildcard_byte_pattern_search verification clean");
        end else begin
            $display("wildcard_byte_pattern_search verification failed");
        end
        $finish;
    end

endmodule
